FILE: sv/lfms_pkg.sv
// Shared types, constants and helpers for the line follower steering core.
`default_nettype none
package lfms_pkg;

   localparam int unsigned LEVEL_W = 12;
   localparam int unsigned SPEEDS_W = 24;
   localparam int unsigned SPEED_W = 9;
   localparam int unsigned MIX_W = 11;
   localparam int unsigned DRIVE_W = 8;
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned LFMS_QUEUE_DEPTH = 2;

   localparam logic [LEVEL_W-1:0] THRESHOLD_RESET = 12'd1200;
   localparam logic SIDE_SPEEDS_POLARITY_RESET = 1'b0;
   localparam logic TURN_ENABLE_RESET = 1'b1;
   localparam logic [SPEEDS_W-1:0] SIDE_SPEEDS_RESET = 24'h320019;
   localparam logic [SPEEDS_W-1:0] CENTER_SPEEDS_RESET = 24'hF60A32;
   localparam logic [SPEEDS_W-1:0] RECOVERY_SPEEDS_RESET = 24'hEC1E0A;

   localparam logic signed [SPEED_W-1:0] FRONT_PIVOT_TURN = 9'sd70;
   localparam logic signed [SPEED_W-1:0] BLIND_PIVOT_TURN = -9'sd20;
   localparam logic signed [MIX_W-1:0] DRIVE_LIMIT = 11'sd127;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LEVEL_THRESHOLD = 3'd0,
      CSR_LINE_POLARITY = 3'd1,
      CSR_TURN_LOGIC_ENABLE = 3'd2,
      CSR_SIDE_SPEEDS = 3'd3,
      CSR_CENTER_SPEEDS = 3'd4,
      CSR_RECOVERY_SPEEDS = 3'd5
   } csr_index_type;

   typedef enum logic [2:0] {
      MODE_RIGHT = 3'd0,
      MODE_CENTER = 3'd1,
      MODE_LEFT = 3'd2,
      MODE_RECOVER_LEFT = 3'd3,
      MODE_RECOVER_RIGHT = 3'd4,
      MODE_FRONT_PIVOT = 3'd5,
      MODE_BLIND_PIVOT = 3'd6,
      MODE_CENTER_PIVOT = 3'd7
   } mode_type;

   typedef enum logic [1:0] {
      SIDE_NONE = 2'd0,
      SIDE_RIGHT = 2'd1,
      SIDE_LEFT = 2'd2
   } side_type;

   typedef enum logic [1:0] {
      DIR_NONE = 2'd0,
      DIR_RIGHT = 2'd1,
      DIR_LEFT = 2'd2,
      DIR_CENTER = 2'd3
   } direction_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] left_level;
      logic [LEVEL_W-1:0] center_level;
      logic [LEVEL_W-1:0] right_level;
      logic [LEVEL_W-1:0] front_left_level;
      logic [LEVEL_W-1:0] front_right_level;
   } req_payload_type;

   typedef struct packed {
      logic signed [DRIVE_W-1:0] front_left_drive;
      logic signed [DRIVE_W-1:0] back_left_drive;
      logic signed [DRIVE_W-1:0] front_right_drive;
      logic signed [DRIVE_W-1:0] back_right_drive;
      logic [2:0] mode_code;
   } rsp_payload_type;

   typedef struct packed {
      logic [CSR_INDEX_W-1:0] reg_index;
      logic [SPEEDS_W-1:0] wr_data;
   } csr_payload_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] level_threshold;
      logic line_polarity;
      logic turn_logic_enable;
      logic [SPEEDS_W-1:0] side_speeds;
      logic [SPEEDS_W-1:0] center_speeds;
      logic [SPEEDS_W-1:0] recovery_speeds;
   } cfg_type;

   // Classified move handed from front to back.
   typedef struct packed {
      logic signed [SPEED_W-1:0] fwd;
      logic signed [SPEED_W-1:0] str;
      logic signed [SPEED_W-1:0] trn;
      mode_type mode;
   } cmd_type;

endpackage
`default_nettype wire

FILE: sv/lfms_req_if.sv
// Sensor sample channel.
`default_nettype none
interface lfms_req_if;
   logic valid;
   logic ready;
   lfms_pkg::req_payload_type payload;
   modport source(output valid, output payload, input ready);
   modport sink(input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: sv/lfms_rsp_if.sv
// Wheel drive result channel.
`default_nettype none
interface lfms_rsp_if;
   logic valid;
   logic ready;
   lfms_pkg::rsp_payload_type payload;
   modport source(output valid, output payload, input ready);
   modport sink(input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: sv/lfms_csr_if.sv
// Register write channel.
`default_nettype none
interface lfms_csr_if;
   logic valid;
   logic ready;
   lfms_pkg::csr_payload_type payload;
   modport source(output valid, output payload, input ready);
   modport sink(input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: sv/lfms_csr.sv
// Configuration register file.
`default_nettype none
module lfms_csr (
   input  wire logic clock,
   input  wire logic reset,
   lfms_csr_if.sink csr_if,
   output lfms_pkg::cfg_type cfg
);
   import lfms_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_if.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_if.valid) begin
         case (csr_if.payload.reg_index)
            CSR_LEVEL_THRESHOLD:
               cfg_in.level_threshold = csr_if.payload.wr_data[LEVEL_W-1:0];
            CSR_LINE_POLARITY: cfg_in.line_polarity = csr_if.payload.wr_data[0];
            CSR_TURN_LOGIC_ENABLE: cfg_in.turn_logic_enable = csr_if.payload.wr_data[0];
            CSR_SIDE_SPEEDS: cfg_in.side_speeds = csr_if.payload.wr_data;
            CSR_CENTER_SPEEDS: cfg_in.center_speeds = csr_if.payload.wr_data;
            CSR_RECOVERY_SPEEDS: cfg_in.recovery_speeds = csr_if.payload.wr_data;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.level_threshold <= THRESHOLD_RESET;
         cfg_ff.line_polarity <= SIDE_SPEEDS_POLARITY_RESET;
         cfg_ff.turn_logic_enable <= TURN_ENABLE_RESET;
         cfg_ff.side_speeds <= SIDE_SPEEDS_RESET;
         cfg_ff.center_speeds <= CENTER_SPEEDS_RESET;
         cfg_ff.recovery_speeds <= RECOVERY_SPEEDS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

FILE: sv/lfms_front.sv
// Front end: thresholds samples, tracks line state and picks the move.
`default_nettype none
module lfms_front (
   input  wire logic clock,
   input  wire logic reset,
   input  lfms_pkg::cfg_type cfg,
   lfms_req_if.sink req_if,
   input  wire logic queue_full,
   output logic push_valid,
   output lfms_pkg::cmd_type push_cmd
);
   import lfms_pkg::*;

   function automatic logic sees_line(logic [LEVEL_W-1:0] level,
                                      logic [LEVEL_W-1:0] threshold,
                                      logic polarity);
      logic above;
      above = level > threshold;
      return polarity ? above : !above;
   endfunction

   function automatic logic signed [SPEED_W-1:0] speed_byte(logic [SPEEDS_W-1:0] packed_v,
                                                            logic [1:0] which);
      logic [7:0] b;
      b = packed_v[{which, 3'b000} +: 8];
      return {b[7], b};
   endfunction

   side_type side_ff, side_in;
   direction_type dir_ff, dir_in;
   logic fl_seen_ff, fl_seen_in;
   logic fr_seen_ff, fr_seen_in;
   logic found_ff, found_in;
   logic dropped_ff, dropped_in;

   logic l_hit, c_hit, r_hit, fl_hit, fr_hit, lost, accept;
   cmd_type cmd;

   assign req_if.ready = !queue_full;
   assign accept = req_if.valid && !queue_full;
   assign push_valid = accept;
   assign push_cmd = cmd;

   always_comb begin
      l_hit = sees_line(req_if.payload.left_level, cfg.level_threshold, cfg.line_polarity);
      c_hit = sees_line(req_if.payload.center_level, cfg.level_threshold, cfg.line_polarity);
      r_hit = sees_line(req_if.payload.right_level, cfg.level_threshold, cfg.line_polarity);
      fl_hit = sees_line(req_if.payload.front_left_level, cfg.level_threshold,
                         cfg.line_polarity);
      fr_hit = sees_line(req_if.payload.front_right_level, cfg.level_threshold,
                         cfg.line_polarity);
      lost = !(l_hit || c_hit || r_hit);

      fl_seen_in = fl_seen_ff;
      fr_seen_in = fr_seen_ff;
      if (cfg.turn_logic_enable) begin
         if (found_ff && dropped_ff) begin
            fl_seen_in = 1'b0;
            fr_seen_in = 1'b0;
         end
         fl_seen_in = fl_seen_in || fl_hit;
         fr_seen_in = fr_seen_in || fr_hit;
      end

      side_in = side_ff;
      dir_in = dir_ff;
      cmd.fwd = '0;
      cmd.str = '0;
      cmd.trn = '0;
      cmd.mode = MODE_RIGHT;
      if (r_hit) begin
         cmd.fwd = speed_byte(cfg.side_speeds, 2'd0);
         cmd.str = speed_byte(cfg.side_speeds, 2'd1);
         cmd.trn = speed_byte(cfg.side_speeds, 2'd2);
         side_in = SIDE_RIGHT;
         dir_in = DIR_RIGHT;
         cmd.mode = MODE_RIGHT;
      end
      if (l_hit) begin
         cmd.fwd = speed_byte(cfg.side_speeds, 2'd0);
         cmd.str = -speed_byte(cfg.side_speeds, 2'd1);
         cmd.trn = -speed_byte(cfg.side_speeds, 2'd2);
         side_in = SIDE_LEFT;
         dir_in = DIR_LEFT;
         cmd.mode = MODE_LEFT;
      end
      if (c_hit) begin
         cmd.fwd = speed_byte(cfg.center_speeds, 2'd0);
         cmd.str = '0;
         cmd.trn = '0;
         if (l_hit && !r_hit) begin
            cmd.str = speed_byte(cfg.center_speeds, 2'd1);
            cmd.trn = speed_byte(cfg.center_speeds, 2'd2);
         end else if (r_hit && !l_hit) begin
            cmd.str = -speed_byte(cfg.center_speeds, 2'd1);
            cmd.trn = -speed_byte(cfg.center_speeds, 2'd2);
         end
         dir_in = DIR_CENTER;
         cmd.mode = MODE_CENTER;
      end

      found_in = !lost;
      dropped_in = dropped_ff || lost;
      if (lost) begin
         if (cfg.turn_logic_enable && fl_seen_in) begin
            cmd.trn = FRONT_PIVOT_TURN;
            cmd.mode = MODE_FRONT_PIVOT;
         end else if (cfg.turn_logic_enable && fr_seen_in) begin
            cmd.trn = -FRONT_PIVOT_TURN;
            cmd.mode = MODE_FRONT_PIVOT;
         end else if (side_ff == SIDE_LEFT) begin
            cmd.fwd = speed_byte(cfg.recovery_speeds, 2'd0);
            cmd.str = speed_byte(cfg.recovery_speeds, 2'd1);
            cmd.trn = speed_byte(cfg.recovery_speeds, 2'd2);
            cmd.mode = MODE_RECOVER_LEFT;
         end else if (side_ff == SIDE_RIGHT) begin
            cmd.fwd = speed_byte(cfg.recovery_speeds, 2'd0);
            cmd.str = -speed_byte(cfg.recovery_speeds, 2'd1);
            cmd.trn = -speed_byte(cfg.recovery_speeds, 2'd2);
            cmd.mode = MODE_RECOVER_RIGHT;
         end else begin
            cmd.trn = BLIND_PIVOT_TURN;
            cmd.mode = (dir_ff == DIR_CENTER) ? MODE_CENTER_PIVOT : MODE_BLIND_PIVOT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff <= SIDE_NONE;
         dir_ff <= DIR_NONE;
         fl_seen_ff <= 1'b0;
         fr_seen_ff <= 1'b0;
         found_ff <= 1'b1;
         dropped_ff <= 1'b0;
      end else if (accept) begin
         side_ff <= side_in;
         dir_ff <= dir_in;
         fl_seen_ff <= fl_seen_in;
         fr_seen_ff <= fr_seen_in;
         found_ff <= found_in;
         dropped_ff <= dropped_in;
      end
   end

endmodule
`default_nettype wire

FILE: sv/lfms_queue.sv
// Short command queue between front and back.
`default_nettype none
module lfms_queue #(
   parameter int unsigned Depth = lfms_pkg::LFMS_QUEUE_DEPTH
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push_valid,
   input  lfms_pkg::cmd_type push_cmd,
   output logic full,
   output logic pop_valid,
   output lfms_pkg::cmd_type pop_cmd,
   input  wire logic pop
);
   import lfms_pkg::*;

   localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] DepthCount = CntW'(Depth);

   cmd_type mem_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full = (count_ff == DepthCount);
   assign pop_valid = (count_ff != '0);
   assign pop_cmd = mem_ff[rd_ptr_ff];
   assign do_push = push_valid && !full;
   assign do_pop = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

FILE: sv/lfms_back.sv
// Back end: mecanum mix, saturation and result register.
`default_nettype none
module lfms_back (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic cmd_valid,
   input  lfms_pkg::cmd_type cmd,
   output logic cmd_pop,
   lfms_rsp_if.source rsp_if
);
   import lfms_pkg::*;

   function automatic logic signed [DRIVE_W-1:0] sat_drive(logic signed [MIX_W-1:0] v);
      logic signed [MIX_W-1:0] r;
      r = v;
      if (v > DRIVE_LIMIT) begin
         r = DRIVE_LIMIT;
      end else if (v < -DRIVE_LIMIT) begin
         r = -DRIVE_LIMIT;
      end
      return r[DRIVE_W-1:0];
   endfunction

   logic out_valid_ff, out_valid_in;
   rsp_payload_type out_ff, out_in;
   logic signed [MIX_W-1:0] f, s, t;

   assign cmd_pop = cmd_valid && (!out_valid_ff || rsp_if.ready);
   assign rsp_if.valid = out_valid_ff;
   assign rsp_if.payload = out_ff;

   always_comb begin
      f = MIX_W'(cmd.fwd);
      s = MIX_W'(cmd.str);
      t = MIX_W'(cmd.trn);
      out_in.front_left_drive = sat_drive(f + t + s);
      out_in.back_left_drive = sat_drive(f + t - s);
      out_in.front_right_drive = sat_drive(f - t - s);
      out_in.back_right_drive = sat_drive(f - t + s);
      out_in.mode_code = cmd.mode;
      out_valid_in = out_valid_ff;
      if (cmd_pop) begin
         out_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

endmodule
`default_nettype wire

FILE: sv/line_follower_mecanum_steering_core.sv
// Top level of the line follower mecanum steering core.
// Takes one transaction of five sensor samples per clock while the queue is not full and
// returns one transaction of four saturated wheel drives plus a mode code for each.
// Thresholding, line tracking and speed selection finish in the accept cycle; a command
// queue (QueueDepth entries) then carries the move to the mixing back end and its output
// register, and lets the sample side keep flowing for that many transactions while the
// result side stalls. Registers may be written while no transaction is in flight.
`default_nettype none
module line_follower_mecanum_steering_core #(
   parameter int unsigned QueueDepth = lfms_pkg::LFMS_QUEUE_DEPTH
) (
   input  wire logic clock,
   input  wire logic reset,
   lfms_req_if.sink req_if,
   lfms_rsp_if.source rsp_if,
   lfms_csr_if.sink csr_if
);
   import lfms_pkg::*;

   cfg_type cfg;
   logic queue_full, push_valid, pop_valid, pop;
   cmd_type push_cmd, pop_cmd;

   lfms_csr u_csr (
      .clock(clock),
      .reset(reset),
      .csr_if(csr_if),
      .cfg(cfg)
   );

   lfms_front u_front (
      .clock(clock),
      .reset(reset),
      .cfg(cfg),
      .req_if(req_if),
      .queue_full(queue_full),
      .push_valid(push_valid),
      .push_cmd(push_cmd)
   );

   lfms_queue #(
      .Depth(QueueDepth)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push_valid(push_valid),
      .push_cmd(push_cmd),
      .full(queue_full),
      .pop_valid(pop_valid),
      .pop_cmd(pop_cmd),
      .pop(pop)
   );

   lfms_back u_back (
      .clock(clock),
      .reset(reset),
      .cmd_valid(pop_valid),
      .cmd(pop_cmd),
      .cmd_pop(pop),
      .rsp_if(rsp_if)
   );

endmodule
`default_nettype wire
